[src/ffpa_pkg.sv]
// Package for the first-fit pool allocator: sizes, status codes, the none pointer.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ffpa_pkg;
  localparam int PoolUnits = 1024;
  localparam int HeaderUnits = 1;
  localparam int AW = 10;             // block address bits
  localparam int PW = 11;             // pointer / size bits (holds PoolUnits)
  localparam logic [PW-1:0] NONE_PTR = PW'(PoolUnits);
  localparam logic [PW-1:0] HDR = PW'(HeaderUnits);

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_OOM = 2'd1;
  localparam logic [1:0] ST_BAD = 2'd2;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE = 1'b1;

  // memory port request
  typedef struct packed {
    logic [AW-1:0] addr;
    logic we_link;
    logic we_size;
    logic [PW-1:0] link;
    logic [PW-1:0] size;
  } mem_req_t;
endpackage
`default_nettype wire

[src/ffpa_mem.sv]
// Block header memory: link and size per block address, one port, registered read.
// Depends on ffpa_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ffpa_mem
  import ffpa_pkg::*;
(
  input  wire logic clk,
  input  wire mem_req_t req,
  output logic [PW-1:0] rd_link,
  output logic [PW-1:0] rd_size
);
  logic [PW-1:0] link_mem [PoolUnits];
  logic [PW-1:0] size_mem [PoolUnits];

  // write-first not needed: the sequencer never reads what it just wrote
  always_ff @(posedge clk) begin
    if (req.we_link) link_mem[req.addr] <= req.link;
    if (req.we_size) size_mem[req.addr] <= req.size;
    rd_link <= link_mem[req.addr];
    rd_size <= size_mem[req.addr];
  end
endmodule
`default_nettype wire

[src/first_fit_pool_allocator_unit.sv]
// First-fit pool allocator top level: list-walking sequencer around the header memory.
// Depends on ffpa_pkg and ffpa_mem.
//
//   channel  dir  fields (low bit up)
//   s_axis   in   tdata: mode, request_size, handle_in
//   m_axis   out  tdata: status, handle_out, granted_size, used_units,
//                        used_with_headers, live_blocks
//
// Each request walks a linked list in the header memory, a read state and a check state
// per list node (read address, then data). After reset a setup state writes the first
// block header before requests are taken. One request is in work at a time; a finished
// result waits in the output register while the next request is accepted.
`timescale 1ns / 1ps
`default_nettype none
module first_fit_pool_allocator_unit
  import ffpa_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,  // mode, request_size, handle_in
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [55:0]      m_axis_tdata   // status, handle_out, granted_size,
                                          // used_units, used_with_headers, live_blocks
);
  localparam logic [4:0] S_INIT   = 5'd0;
  localparam logic [4:0] S_IDLE   = 5'd1;
  localparam logic [4:0] S_A_RD   = 5'd2;   // alloc walk read issued
  localparam logic [4:0] S_A_CHK  = 5'd3;
  localparam logic [4:0] S_A_W1   = 5'd4;   // split header
  localparam logic [4:0] S_A_W2   = 5'd5;   // prev link
  localparam logic [4:0] S_A_W3   = 5'd6;   // cur link/size
  localparam logic [4:0] S_F_RD   = 5'd7;   // alloc-list walk
  localparam logic [4:0] S_F_CHK  = 5'd8;
  localparam logic [4:0] S_F_UNL  = 5'd9;
  localparam logic [4:0] S_G_RD   = 5'd10;  // free-list walk
  localparam logic [4:0] S_G_CHK  = 5'd11;  // read the block after hdr
  localparam logic [4:0] S_G_CUR  = 5'd12;  // its data, merge with hdr
  localparam logic [4:0] S_G_PRD  = 5'd13;
  localparam logic [4:0] S_G_WH   = 5'd14;  // write hdr
  localparam logic [4:0] S_G_WP   = 5'd15;  // write prev
  localparam logic [4:0] S_DONE   = 5'd16;

  logic [4:0] state;
  logic [PW-1:0] want, hdr, hsize, hlink;
  logic [PW-1:0] cur, prev, csize, clink, psize;
  logic [PW-1:0] free_head, alloc_head;
  logic [PW-1:0] payload_count, gross_count;
  logic [AW-1:0] block_count;
  logic [PW-1:0] guard;
  logic [1:0]  r_status;
  logic [AW-1:0] r_handle;
  logic [PW-1:0] r_granted;
  logic       out_valid;
  mem_req_t   req;
  logic [PW-1:0] rd_link, rd_size;

  ffpa_mem u_mem (.clk(clk), .req(req), .rd_link(rd_link), .rd_size(rd_size));

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = out_valid;

  // derived values
  logic [PW:0] nb_w;
  logic [PW-1:0] nb;
  logic          fits, split, nb_ok;
  assign fits  = rd_size >= want;
  assign split = {1'b0, rd_size} > ({1'b0, want} + {1'b0, HDR});
  assign nb_w  = {1'b0, cur} + {1'b0, HDR} + {1'b0, want};
  assign nb    = nb_w[PW-1:0];
  assign nb_ok = nb_w < (PW+1)'(PoolUnits);

  logic [PW+1:0] hend, pend;
  assign hend = {2'b0, hdr} + {2'b0, hsize} + {2'b0, HDR};
  assign pend = {2'b0, prev} + {2'b0, psize} + {2'b0, HDR};

  // memory port
  always_comb begin
    req = '0;
    case (state)
      S_INIT: begin
        req.we_link = 1'b1; req.we_size = 1'b1;
        req.link = NONE_PTR; req.size = PW'(PoolUnits - HeaderUnits);
      end
      S_A_RD, S_F_RD, S_G_RD, S_G_CHK: req.addr = cur[AW-1:0];
      S_A_W1: begin
        req.addr = nb[AW-1:0]; req.we_link = 1'b1; req.we_size = 1'b1;
        req.link = clink; req.size = csize - want - HDR;
      end
      S_A_W2: begin
        req.addr = prev[AW-1:0]; req.we_link = (prev != NONE_PTR);
        req.link = hlink;
      end
      S_A_W3: begin
        req.addr = cur[AW-1:0]; req.we_link = 1'b1; req.we_size = 1'b1;
        req.link = alloc_head; req.size = hsize;
      end
      S_F_UNL: begin
        req.addr = prev[AW-1:0]; req.we_link = (prev != NONE_PTR);
        req.link = clink;
      end
      S_G_WH: begin
        req.addr = hdr[AW-1:0]; req.we_link = 1'b1; req.we_size = 1'b1;
        req.link = hlink; req.size = hsize;
      end
      S_G_WP: begin
        // prev either absorbs hdr or just points to it
        req.addr = prev[AW-1:0]; req.we_link = 1'b1; req.we_size = 1'b1;
        if (pend == {2'b0, hdr}) begin
          req.link = hlink; req.size = psize + hsize + HDR;
        end else begin
          req.link = hdr; req.size = psize;
        end
      end
      default: req = '0;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      free_head <= '0;
      alloc_head <= NONE_PTR;
      payload_count <= '0;
      gross_count <= '0;
      block_count <= '0;
      out_valid <= 1'b0;
    end else begin
      // output register: load a finished result, drop it once taken
      if (state == S_DONE && (!out_valid || m_axis_tready)) out_valid <= 1'b1;
      else if (m_axis_tready) out_valid <= 1'b0;
      case (state)
        S_INIT: state <= S_IDLE;
        S_IDLE: begin
          if (s_axis_tvalid && s_axis_tready) begin
            want <= (s_axis_tdata[11:1] == '0) ? PW'(1) : s_axis_tdata[11:1];
            hdr <= {1'b0, s_axis_tdata[21:12]} - HDR;
            prev <= NONE_PTR;
            guard <= '0;
            r_handle <= '0;
            r_granted <= '0;
            if (s_axis_tdata[0] == MODE_ALLOC) begin
              cur <= free_head;
              state <= (free_head == NONE_PTR) ? S_DONE : S_A_RD;
              r_status <= ST_OOM;
            end else begin
              cur <= alloc_head;
              r_status <= ST_BAD;
              state <= ({1'b0, s_axis_tdata[21:12]} < HDR || alloc_head == NONE_PTR)
                       ? S_DONE : S_F_RD;
            end
          end
        end
        // first-fit walk
        S_A_RD: state <= S_A_CHK;
        S_A_CHK: begin
          csize <= rd_size;
          clink <= rd_link;
          if (fits) begin
            if (split) begin
              if (!nb_ok) state <= S_DONE;
              else begin
                hsize <= want; hlink <= nb; state <= S_A_W1;
              end
            end else begin
              hsize <= rd_size; hlink <= rd_link; state <= S_A_W2;
            end
          end else if (rd_link == NONE_PTR || guard == NONE_PTR) begin
            state <= S_DONE;
          end else begin
            prev <= cur; cur <= rd_link; guard <= guard + 1'b1; state <= S_A_RD;
          end
        end
        S_A_W1: state <= S_A_W2;
        S_A_W2: begin
          if (prev == NONE_PTR) free_head <= hlink;
          state <= S_A_W3;
        end
        S_A_W3: begin
          alloc_head <= cur;
          payload_count <= payload_count + hsize;
          gross_count <= gross_count + hsize + HDR;
          block_count <= block_count + 1'b1;
          r_status <= ST_OK;
          r_handle <= AW'(cur + HDR);
          r_granted <= hsize;
          state <= S_DONE;
        end
        // handle check on the allocated list
        S_F_RD: state <= S_F_CHK;
        S_F_CHK: begin
          if (cur == hdr) begin
            clink <= rd_link; hsize <= rd_size; state <= S_F_UNL;
          end else if (rd_link == NONE_PTR || guard == NONE_PTR) begin
            state <= S_DONE;
          end else begin
            prev <= cur; cur <= rd_link; guard <= guard + 1'b1; state <= S_F_RD;
          end
        end
        S_F_UNL: begin
          if (prev == NONE_PTR) alloc_head <= clink;
          payload_count <= payload_count - hsize;
          gross_count <= gross_count - hsize - HDR;
          block_count <= block_count - 1'b1;
          r_status <= ST_OK;
          prev <= NONE_PTR;
          cur <= free_head;
          guard <= '0;
          state <= (free_head == NONE_PTR || free_head >= hdr) ? S_G_CHK : S_G_RD;
        end
        // address-ordered walk of the free list; prev keeps its size for the merge
        S_G_RD: state <= S_G_PRD;
        S_G_PRD: begin
          prev <= cur; cur <= rd_link; psize <= rd_size; guard <= guard + 1'b1;
          if (rd_link == NONE_PTR || rd_link >= hdr || guard == NONE_PTR) state <= S_G_CHK;
          else state <= S_G_RD;
        end
        S_G_CHK: begin
          hlink <= cur;
          state <= S_G_CUR;
        end
        // absorb the following block when it abuts hdr
        S_G_CUR: begin
          if (cur != NONE_PTR && hend == {2'b0, cur}) begin
            hsize <= hsize + rd_size + HDR;
            hlink <= rd_link;
          end
          state <= S_G_WH;
        end
        S_G_WH: begin
          if (prev == NONE_PTR) begin
            free_head <= hdr;
            state <= S_DONE;
          end else begin
            state <= S_G_WP;
          end
        end
        S_G_WP: state <= S_DONE;
        S_DONE: begin
          if (!out_valid || m_axis_tready) begin
            m_axis_tdata <= {1'b0, block_count, gross_count, payload_count,
                             r_granted, r_handle, r_status};
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

[tb/tb.sv]
// Self-checking testbench for first_fit_pool_allocator_unit: allocate/free request stream
// checked against an in-bench allocator predictor. Depends on ffpa_pkg and the RTL.
`timescale 1ns / 1ps
module tb;
  import ffpa_pkg::*;

  typedef struct packed {
    logic [9:0]  live_blocks;
    logic [10:0] used_with_headers;
    logic [10:0] used_units;
    logic [10:0] granted_size;
    logic [9:0]  handle_out;
    logic [1:0]  status;
  } reply_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;   // mode, request_size, handle_in
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;        // status, handle_out, granted_size, used_units, ...

  first_fit_pool_allocator_unit dut (.*);

  always #10 clk = ~clk;

  // predictor state: header memory, list heads, counters
  int unsigned nxt[PoolUnits];
  int unsigned bsz[PoolUnits];
  int unsigned free_top, alloc_top, pay_cnt, gross_cnt, blk_cnt;

  logic [23:0] pending_req[$];
  reply_t      expected_reply[$];
  int unsigned live_handles[$];
  int          errors = 0;
  int          n_alloc = 0, n_free = 0, n_oom = 0, n_bad = 0;
  int          n_sent = 0;

  // idle percentage for each quarter of the run
  function automatic int idle_pct(int n, bit rx);
    case (n / 380)
      0: return 0;
      1: return rx ? 0 : 56;
      2: return rx ? 56 : 0;
      default: return 10;
    endcase
  endfunction

  function automatic void pool_reset();
    foreach (nxt[i]) begin
      nxt[i] = 0;
      bsz[i] = 0;
    end
    nxt[0] = PoolUnits;
    bsz[0] = PoolUnits - HeaderUnits;
    free_top = 0;
    alloc_top = PoolUnits;
    pay_cnt = 0;
    gross_cnt = 0;
    blk_cnt = 0;
  endfunction

  function automatic logic [1:0] grant(int unsigned want, output int unsigned h,
                                       output int unsigned g);
    int unsigned prv, cur, sz, rest, nb;
    prv = PoolUnits;
    cur = free_top;
    h = 0;
    g = 0;
    if (want == 0) want = 1;
    while (cur < PoolUnits) begin
      sz = bsz[cur];
      if (sz >= want) begin
        if (sz <= want + HeaderUnits) rest = nxt[cur];
        else begin
          nb = cur + HeaderUnits + want;
          if (nb >= PoolUnits) return ST_OOM;
          nxt[nb] = nxt[cur];
          bsz[nb] = sz - want - HeaderUnits;
          bsz[cur] = want;
          rest = nb;
        end
        if (prv < PoolUnits) nxt[prv] = rest;
        else free_top = rest;
        nxt[cur] = alloc_top;
        alloc_top = cur;
        pay_cnt += bsz[cur];
        gross_cnt += bsz[cur] + HeaderUnits;
        blk_cnt++;
        h = cur + HeaderUnits;
        g = bsz[cur];
        return ST_OK;
      end
      prv = cur;
      cur = nxt[cur];
    end
    return ST_OOM;
  endfunction

  function automatic logic [1:0] release_block(int unsigned h);
    int unsigned hdr, prv, cur;
    bit found;
    found = 0;
    if (h < HeaderUnits) return ST_BAD;
    hdr = h - HeaderUnits;
    prv = PoolUnits;
    cur = alloc_top;
    while (cur < PoolUnits) begin
      if (cur == hdr) begin
        found = 1;
        break;
      end
      prv = cur;
      cur = nxt[cur];
    end
    if (!found) return ST_BAD;
    if (prv < PoolUnits) nxt[prv] = nxt[hdr];
    else alloc_top = nxt[hdr];
    pay_cnt -= bsz[hdr];
    gross_cnt -= bsz[hdr] + HeaderUnits;
    blk_cnt--;
    // insert into free list by address, then merge with neighbors
    prv = PoolUnits;
    cur = free_top;
    while (cur < PoolUnits && cur < hdr) begin
      prv = cur;
      cur = nxt[cur];
    end
    nxt[hdr] = cur;
    if (prv < PoolUnits) nxt[prv] = hdr;
    else free_top = hdr;
    if (cur < PoolUnits && hdr + bsz[hdr] + HeaderUnits == cur) begin
      bsz[hdr] += bsz[cur] + HeaderUnits;
      nxt[hdr] = nxt[cur];
    end
    if (prv < PoolUnits && prv + bsz[prv] + HeaderUnits == hdr) begin
      bsz[prv] += bsz[hdr] + HeaderUnits;
      nxt[prv] = nxt[hdr];
    end
    return ST_OK;
  endfunction

  function automatic reply_t predict_reply(logic [23:0] req);
    reply_t r;
    int unsigned h, g;
    h = 0;
    g = 0;
    if (req[0] == MODE_ALLOC) r.status = grant(req[11:1], h, g);
    else r.status = release_block(req[21:12]);
    r.handle_out = h[9:0];
    r.granted_size = g[10:0];
    r.used_units = pay_cnt[10:0];
    r.used_with_headers = gross_cnt[10:0];
    r.live_blocks = blk_cnt[9:0];
    return r;
  endfunction

  // queue a request for the driver; live_handles shadows granted handles so frees are mostly valid
  function automatic void queue_req(logic mode, logic [10:0] sz, logic [9:0] h);
    pending_req.push_back({2'b00, h, sz, mode});
  endfunction

  // driver: predicts at acceptance, random gaps per phase
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_reply.push_back(predict_reply(s_axis_tdata));
        void'(pending_req.pop_front());
        n_sent++;
      end
      if ((!s_axis_tvalid || s_axis_tready) && pending_req.size() > 0 &&
          $urandom_range(99) >= idle_pct(n_sent, 1'b0)) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= pending_req[0];
      end else if (s_axis_tvalid && s_axis_tready) begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // monitor: random backpressure, compares against oldest prediction
  always @(posedge clk) begin
    reply_t got, exp_r;
    if (!rst) begin
      m_axis_tready <= ($urandom_range(99) >= idle_pct(n_sent, 1'b1));
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[54:0];
        if (expected_reply.size() == 0) begin
          $error("unexpected reply %h", m_axis_tdata);
          errors++;
        end else begin
          exp_r = expected_reply.pop_front();
          case (got.status)
            ST_OK:   if (got.granted_size != 0) n_alloc++; else n_free++;
            ST_OOM:  n_oom++;
            default: n_bad++;
          endcase
          if (got.status != exp_r.status) begin
            $error("status exp %0d got %0d", exp_r.status, got.status); errors++;
          end
          if (got.handle_out != exp_r.handle_out) begin
            $error("handle_out exp %0d got %0d", exp_r.handle_out, got.handle_out);
            errors++;
          end
          if (got.granted_size != exp_r.granted_size) begin
            $error("granted_size exp %0d got %0d", exp_r.granted_size, got.granted_size);
            errors++;
          end
          if (got.used_units != exp_r.used_units) begin
            $error("used_units exp %0d got %0d", exp_r.used_units, got.used_units);
            errors++;
          end
          if (got.used_with_headers != exp_r.used_with_headers) begin
            $error("used_with_headers exp %0d got %0d", exp_r.used_with_headers,
                   got.used_with_headers);
            errors++;
          end
          if (got.live_blocks != exp_r.live_blocks) begin
            $error("live_blocks exp %0d got %0d", exp_r.live_blocks, got.live_blocks);
            errors++;
          end
        end
      end
    end
  end

  // stimulus: directed corner cases then random traffic, all built before reset ends
  initial begin
    int unsigned sim_h, sim_g, pick, sz;
    logic [1:0] st;
    pool_reset();

    // directed: zero size, full pool, oom, bad handles, double free, merges
    queue_req(MODE_ALLOC, 11'd0, 10'd0);
    queue_req(MODE_FREE, 11'd0, 10'd1);
    queue_req(MODE_ALLOC, 11'd1023, 10'd0);
    queue_req(MODE_ALLOC, 11'd1, 10'd0);
    queue_req(MODE_FREE, 11'd0, 10'd0);
    queue_req(MODE_FREE, 11'd0, 10'd1023);
    queue_req(MODE_FREE, 11'd0, 10'd1);
    queue_req(MODE_FREE, 11'd0, 10'd1);
    queue_req(MODE_ALLOC, 11'd2047, 10'd0);
    queue_req(MODE_ALLOC, 11'd1024, 10'd0);
    queue_req(MODE_ALLOC, 11'd1022, 10'd0);
    queue_req(MODE_FREE, 11'd0, 10'd1);
    queue_req(MODE_ALLOC, 11'd10, 10'd0);
    queue_req(MODE_ALLOC, 11'd20, 10'd0);
    queue_req(MODE_ALLOC, 11'd30, 10'd0);
    queue_req(MODE_FREE, 11'd0, 10'd12);
    queue_req(MODE_FREE, 11'd0, 10'd1);
    queue_req(MODE_FREE, 11'd0, 10'd33);
    queue_req(MODE_ALLOC, 11'd1021, 10'd0);
    queue_req(MODE_FREE, 11'd0, 10'd1);
    queue_req(MODE_FREE, 11'd0, 10'd682);

    // replay directed items into the predictor to know live handles
    foreach (pending_req[i]) begin
      if (pending_req[i][0] == MODE_ALLOC) begin
        st = grant(pending_req[i][11:1], sim_h, sim_g);
        if (st == ST_OK) live_handles.push_back(sim_h);
      end else begin
        st = release_block(pending_req[i][21:12]);
        foreach (live_handles[j])
          if (live_handles[j] == pending_req[i][21:12]) begin
            live_handles.delete(j);
            break;
          end
      end
    end
    for (int k = 0; k < 1500; k++) begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        sz = ($urandom_range(9) == 0) ? $urandom_range(2047) : $urandom_range(1, 40);
        queue_req(MODE_ALLOC, sz[10:0], 10'($urandom));
        st = grant(sz, sim_h, sim_g);
        if (st == ST_OK) live_handles.push_back(sim_h);
      end else if (pick < 92 && live_handles.size() > 0) begin
        sz = $urandom_range(live_handles.size() - 1);
        sim_h = live_handles[sz];
        live_handles.delete(sz);
        queue_req(MODE_FREE, 11'($urandom), sim_h[9:0]);
        st = release_block(sim_h);
      end else begin
        sim_h = $urandom_range(1023);
        queue_req(MODE_FREE, 11'($urandom), sim_h[9:0]);
        st = release_block(sim_h);
        foreach (live_handles[j])
          if (live_handles[j] == sim_h) begin
            live_handles.delete(j);
            break;
          end
      end
    end
    // back to the reset image; the driver predicts again at acceptance
    pool_reset();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
  end

  initial begin
    #1000;
    wait (!rst && pending_req.size() == 0 && !s_axis_tvalid && expected_reply.size() == 0);
    repeat (50) @(posedge clk);
    $display("Covered %0d grants, %0d releases, %0d out-of-memory, %0d refused frees",
             n_alloc, n_free, n_oom, n_bad);
    $display("across four handshake idling phases.");
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #200ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

[files.f]
src/ffpa_pkg.sv
src/ffpa_mem.sv
src/first_fit_pool_allocator_unit.sv
tb/tb.sv
